FILE: rtl/core/dstwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg
// Widths, register indexes and constants shared by the ranging unit.
// ----------------------------------------------------------------------------
package dstwr_pkg;

  // Field widths
  localparam int STAMP_W = 40;
  localparam int WORD_W  = 32;
  localparam int ANT_W   = 16;
  localparam int SCALE_W = 24;
  localparam int DEN_W   = 34;   // sum of four 32-bit intervals
  localparam int PROD_W  = 64;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 144;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESP_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ANT_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MM_PER_TICK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COORD_MODE  = 2'd3;

  localparam logic [SCALE_W-1:0] MM_PER_TICK_RESET = 24'd307474;

  // Item kinds, carried on tuser
  localparam logic ACTION_POLL  = 1'b0;
  localparam logic ACTION_FINAL = 1'b1;
  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_RANGE    = 1'b1;

  // Clears bit 0 of the delayed transmit word
  localparam logic [WORD_W-1:0] EVEN_WORD_MASK = 32'hFFFF_FFFE;

  localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage : dstwr_pkg
`default_nettype wire

FILE: rtl/core/ds_twr_time_of_flight_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_unit
// Anchor side of asymmetric double-sided two-way ranging: response scheduling
// and exact time-of-flight and distance computation.
// ----------------------------------------------------------------------------
// A poll transaction (in_tuser = 0) stores its receive stamp and yields a
// schedule result holding the delayed transmit word (bits 39..8 of stamp plus
// response delay) and the predicted response stamp. A final transaction
// (in_tuser = 1) forms the four wrapped 32-bit intervals Ra, Rb, Da and Db
// and yields a range result holding
// (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db), truncated toward zero and saturated to
// signed 32 bits, and the same figure scaled to millimetres. One 32x32
// multiplier is shared for both interval products and the millimetre scaling,
// and the division is a restoring divider that retires one quotient bit per
// cycle until all 64 quotient bits are formed.
// When the interval sum is zero the result carries bad_denominator set with
// zero flight time and distance. The unit takes one item at a time; in_tready
// rises again as soon as the result is staged in the output register, so the
// next item may be accepted while a result waits to be taken. In coordinator
// mode items are accepted and dropped without effect. Configuration writes are
// always accepted and are meant to happen only while the unit is idle.
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [39:0] local_rx_stamp, [79:40] local_tx_stamp, [111:80] peer_poll_tx,
  // [143:112] peer_resp_rx, [175:144] peer_final_tx
  input  wire logic [dstwr_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  // Result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] delayed_tx_word, [71:32] predicted_resp_stamp, [103:72] flight_ticks,
  // [135:104] distance_mm, [136] bad_denominator, [143:137] zero
  output logic [dstwr_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [0] result_kind
  output logic                                   out_tuser,
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dstwr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dstwr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dstwr_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_POLL1 = 4'd1;
  localparam logic [3:0] ST_POLL2 = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_SUB   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SAT   = 4'd7;
  localparam logic [3:0] ST_MUL3  = 4'd8;
  localparam logic [3:0] ST_WR    = 4'd9;

  // Configuration registers
  logic [WORD_W-1:0]  resp_delay_r;
  logic [ANT_W-1:0]   ant_delay_r;
  logic [SCALE_W-1:0] mm_per_tick_r;
  logic               coord_mode_r;

  logic [STAMP_W-1:0] last_poll_r;

  logic [3:0] state_r, state_nxt;

  // Working registers
  logic [STAMP_W-1:0] rx_r;
  logic [WORD_W-1:0]  ra_r, rb_r, da_r, db_r;
  logic [DEN_W-1:0]   den_r;
  logic [PROD_W-1:0]  p1_r, prod_r;
  logic [PROD_W-1:0]  dvd_r;       // dividend in, quotient out
  logic [DEN_W-1:0]   rem_r;
  logic [5:0]         cnt_r;
  logic               neg_r;
  logic               tneg_r;
  logic [WORD_W-1:0]  tmag_r;
  logic               kind_r;
  logic               bad_r;
  logic [WORD_W-1:0]  word_r;
  logic [STAMP_W-1:0] pred_r;
  logic [WORD_W-1:0]  tof_r;

  // Output register
  logic               out_valid_r;
  logic               out_kind_r;
  logic [WORD_W-1:0]  out_word_r;
  logic [STAMP_W-1:0] out_pred_r;
  logic [WORD_W-1:0]  out_tof_r;
  logic [WORD_W-1:0]  out_dist_r;
  logic               out_bad_r;

  // Input fields
  logic               in_action;
  logic [STAMP_W-1:0] in_rx, in_tx;
  logic [WORD_W-1:0]  in_ppt, in_prr, in_pft;
  logic               in_fire, out_fire, cfg_fire;

  assign in_action = in_tuser;
  assign in_rx     = in_tdata[39:0];
  assign in_tx     = in_tdata[79:40];
  assign in_ppt    = in_tdata[111:80];
  assign in_prr    = in_tdata[143:112];
  assign in_pft    = in_tdata[175:144];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Shared multiplier: operands chosen by the sequencer
  logic [WORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (state_r)
      ST_MUL1: begin
        mul_a = ra_r;
        mul_b = rb_r;
      end
      ST_MUL2: begin
        mul_a = da_r;
        mul_b = db_r;
      end
      default: begin
        mul_a = tmag_r;
        mul_b = {{(WORD_W-SCALE_W){1'b0}}, mm_per_tick_r};
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Magnitude of the numerator and its sign
  logic              p_neg;
  logic [PROD_W-1:0] p_mag;

  assign p_neg = (p1_r < prod_r);
  assign p_mag = p_neg ? (prod_r - p1_r) : (p1_r - prod_r);

  // One restoring division step
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   rem_diff;
  logic             q_bit;
  logic [DEN_W-1:0] rem_next;

  assign rem_shift = {rem_r, dvd_r[PROD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign q_bit     = (rem_shift >= {1'b0, den_r});
  assign rem_next  = q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];

  // Saturation of the quotient to signed 32 bits
  logic              q_big;
  logic              sat_tneg;
  logic [WORD_W-1:0] sat_tmag;

  assign q_big    = |dvd_r[PROD_W-1:WORD_W-1];
  assign sat_tneg = neg_r && (dvd_r != '0);
  always_comb begin
    if (neg_r) begin
      sat_tmag = q_big ? SAT_NEG : dvd_r[WORD_W-1:0];
    end else begin
      sat_tmag = q_big ? SAT_POS : dvd_r[WORD_W-1:0];
    end
  end

  // Millimetre scaling: Q16 product, then saturation with the flight sign
  logic [38:0]       dmag;
  logic              d_big;
  logic [WORD_W-1:0] dist_val;

  assign dmag  = prod_r[54:16];
  assign d_big = |dmag[38:WORD_W-1];
  always_comb begin
    if (tneg_r) begin
      dist_val = d_big ? SAT_NEG : (~dmag[WORD_W-1:0] + 1'b1);
    end else begin
      dist_val = d_big ? SAT_POS : dmag[WORD_W-1:0];
    end
    if (!kind_r || bad_r) begin
      dist_val = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !coord_mode_r) begin
          state_nxt = (in_action == ACTION_POLL) ? ST_POLL1 : ST_MUL1;
        end
      end
      ST_POLL1: state_nxt = ST_POLL2;
      ST_POLL2: state_nxt = ST_WR;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_SUB;
      ST_SUB:   state_nxt = (den_r == '0) ? ST_WR : ST_DIV;
      ST_DIV:   state_nxt = (cnt_r == '0) ? ST_SAT : ST_DIV;
      ST_SAT:   state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_WR;
      ST_WR: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      resp_delay_r  <= '0;
      ant_delay_r   <= '0;
      mm_per_tick_r <= MM_PER_TICK_RESET;
      coord_mode_r  <= 1'b0;
      last_poll_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_IDX_RESP_DELAY:  resp_delay_r  <= cfg_data;
          CFG_IDX_ANT_DELAY:   ant_delay_r   <= cfg_data[ANT_W-1:0];
          CFG_IDX_MM_PER_TICK: mm_per_tick_r <= cfg_data[SCALE_W-1:0];
          CFG_IDX_COORD_MODE:  coord_mode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire && !coord_mode_r && (in_action == ACTION_POLL)) begin
        last_poll_r <= in_rx;
      end
      if (state_r == ST_WR && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  logic [STAMP_W-1:0] poll_sum;
  assign poll_sum = rx_r + STAMP_W'(resp_delay_r);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rx_r   <= in_rx;
          ra_r   <= in_prr - in_ppt;
          rb_r   <= in_rx[WORD_W-1:0] - in_tx[WORD_W-1:0];
          da_r   <= in_pft - in_prr;
          db_r   <= in_tx[WORD_W-1:0] - last_poll_r[WORD_W-1:0];
          kind_r <= (in_action == ACTION_POLL) ? KIND_SCHEDULE : KIND_RANGE;
          bad_r  <= 1'b0;
          tof_r  <= '0;
          tneg_r <= 1'b0;
          word_r <= '0;
          pred_r <= '0;
        end
      end
      ST_POLL1: begin
        word_r <= poll_sum[STAMP_W-1:8];
      end
      ST_POLL2: begin
        pred_r <= {(word_r & EVEN_WORD_MASK), 8'h00} + STAMP_W'(ant_delay_r);
      end
      ST_MUL1: begin
        p1_r  <= mul_p;
        den_r <= DEN_W'(ra_r) + DEN_W'(rb_r) + DEN_W'(da_r) + DEN_W'(db_r);
      end
      ST_MUL2: begin
        prod_r <= mul_p;
      end
      ST_SUB: begin
        bad_r <= (den_r == '0);
        neg_r <= p_neg;
        dvd_r <= p_mag;
        rem_r <= '0;
        cnt_r <= 6'd63;
      end
      ST_DIV: begin
        rem_r <= rem_next;
        dvd_r <= {dvd_r[PROD_W-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_SAT: begin
        tmag_r <= sat_tmag;
        tneg_r <= sat_tneg;
        tof_r  <= sat_tneg ? (~sat_tmag + 1'b1) : sat_tmag;
      end
      ST_MUL3: begin
        prod_r <= mul_p;
      end
      ST_WR: begin
        if (!out_valid_r || out_tready) begin
          out_kind_r <= kind_r;
          out_word_r <= word_r;
          out_pred_r <= pred_r;
          out_tof_r  <= tof_r;
          out_dist_r <= dist_val;
          out_bad_r  <= bad_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_bad_r, out_dist_r, out_tof_r, out_pred_r, out_word_r};

  // Assertions
  a_div_runs_full : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != '0) |=> (state_r == ST_DIV))
    else $error("division left before all quotient bits were formed");

  a_rem_below_den : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("partial remainder not below the divisor");

  a_coord_drops : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && coord_mode_r) |=> (state_r == ST_IDLE && !$rose(out_valid_r)))
    else $error("item processed in coordinator mode");

  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_tof_r == '0 && out_dist_r == '0 && out_kind_r))
    else $error("zero denominator result carries a non-zero range");

  a_sched_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SCHEDULE) |->
      (out_tof_r == '0 && out_dist_r == '0 && !out_bad_r))
    else $error("schedule result carries range fields");

endmodule : ds_twr_time_of_flight_unit
`default_nettype wire
